[design/wfis_pkg.sv]
// ----------------------------------------------------------------------------
// wfis_pkg
// Shared types and constants for the wide float to IEEE single converter.
// ----------------------------------------------------------------------------
package wfis_pkg;

    localparam int FRAC_W      = 28;
    localparam int EXP_W       = 10;
    localparam int MSB_W       = 5;
    localparam int BIASED_W    = 12;
    localparam logic [BIASED_W-1:0] EXP_OFFSET = 12'd412; // 512 + 27 - 127
    localparam logic [7:0]     IEEE_EXP_MAX = 8'd254;

    // Normalized and rounded fraction, handed to the packing stage
    typedef struct packed {
        logic        zero;
        logic        sign;
        logic [4:0]  msb;
        logic [22:0] mant;
        logic [EXP_W-1:0] exponent;
    } norm_t;

endpackage

[design/wfis_norm.sv]
// ----------------------------------------------------------------------------
// wfis_norm
// Take the magnitude of the fraction, normalize it and round to 24 bits.
// ----------------------------------------------------------------------------
module wfis_norm
    import wfis_pkg::*;
(
    input  logic [EXP_W-1:0]  exponent,
    input  logic [FRAC_W-1:0] raw,
    output norm_t             norm
);

    logic [FRAC_W-1:0] mag;
    logic [4:0]        msb;
    logic [FRAC_W-1:0] shifted;
    logic [24:0]       sig;
    logic [3:0]        low;
    logic              round_up;

    always_comb
    begin
        mag = raw[FRAC_W-1] ? (~raw + 28'd1) : raw;
        msb = 5'd0;
        for (int i = 0; i < FRAC_W; i++)
        begin
            if (mag[i])
                msb = 5'(i);
        end
        // Bring the leading one to bit 27
        shifted = mag << (5'd27 - msb);
        low     = shifted[3:0];
        round_up = shifted[3] && (shifted[2:0] != 3'd0 || shifted[4]);
        sig = {1'b0, shifted[27:4]} + {24'd0, round_up};
        norm.zero     = (raw == '0);
        norm.sign     = raw[FRAC_W-1];
        norm.exponent = exponent;
        if (sig[24])
        begin
            norm.msb  = msb + 5'd1;
            norm.mant = '0;
        end
        else
        begin
            norm.msb  = msb;
            norm.mant = sig[22:0];
        end
        if (low == 4'd0)
            norm.mant = sig[22:0];
    end

endmodule

[design/wfis_pack.sv]
// ----------------------------------------------------------------------------
// wfis_pack
// Form the IEEE exponent, apply underflow and overflow, pack the word.
// ----------------------------------------------------------------------------
module wfis_pack
    import wfis_pkg::*;
(
    input  norm_t       norm,
    output logic [31:0] ieee_single
);

    logic [BIASED_W-1:0] sum;
    logic signed [BIASED_W:0] biased;

    always_comb
    begin
        sum    = {2'd0, norm.exponent} + {7'd0, norm.msb};
        biased = $signed({1'b0, sum}) - $signed({1'b0, EXP_OFFSET});
        if (norm.zero)
            ieee_single = '0;
        else if (biased <= 0)
            ieee_single = {norm.sign, 31'd0};
        else if (biased > $signed({5'd0, IEEE_EXP_MAX}))
            ieee_single = {norm.sign, IEEE_EXP_MAX, norm.mant};
        else
            ieee_single = {norm.sign, biased[7:0], norm.mant};
    end

endmodule

[design/wide_float_to_ieee_single_unit.sv]
// ----------------------------------------------------------------------------
// wide_float_to_ieee_single_unit
// Convert a 10-bit-exponent, 28-bit-fraction float to an IEEE single word.
// ----------------------------------------------------------------------------
// Usage:
//   Drive exponent, fraction_high and fraction_low and raise start; the
//   request is taken at any edge where start is high (busy is always low).
//   The request is captured in an input register; normalization, rounding
//   and packing run as one combinational pass into the result register.
//   done pulses for one cycle with ieee_single once the request has passed
//   through the input register and the result register. One request per cycle is
//   sustained, set by the single pass between the two registers.
//   The receiver cannot stall: each result shows for exactly one cycle.
//   Reset clears the valid flags; no result is pending after reset.
// ----------------------------------------------------------------------------
module wide_float_to_ieee_single_unit
    import wfis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [EXP_W-1:0]  exponent,
    input  logic [11:0]       fraction_high,
    input  logic [15:0]       fraction_low,
    output logic              done,
    output logic [31:0]       ieee_single
);

    logic              in_valid_reg;
    logic [EXP_W-1:0]  exp_reg;
    logic [FRAC_W-1:0] raw_reg;
    logic              out_valid_reg;
    logic [31:0]       result_reg;
    logic [31:0]       result_next;
    norm_t             norm;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            exp_reg <= exponent;
            raw_reg <= {fraction_high, fraction_low};
        end
        if (in_valid_reg)
            result_reg <= result_next;
    end

    wfis_norm u_norm
    (
        .exponent (exp_reg),
        .raw      (raw_reg),
        .norm     (norm)
    );

    wfis_pack u_pack
    (
        .norm        (norm),
        .ieee_single (result_next)
    );

    assign done        = out_valid_reg;
    assign ieee_single = result_reg;

endmodule

[sim/wfis_checker.sv]
// ----------------------------------------------------------------------------
// wfis_checker
// Watches the request and result channels of the converter, predicts each
// IEEE single word and compares it with the one the unit returns.
// ----------------------------------------------------------------------------
module wfis_checker
    import wfis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [EXP_W-1:0]  exponent,
    input  logic [11:0]       fraction_high,
    input  logic [15:0]       fraction_low,
    input  logic              done,
    input  logic [31:0]       ieee_single,
    output int                fail_count,
    output int                pending_count,
    output int                result_count
);

    logic [31:0] expected_words[$];

    function automatic logic [31:0] predict_single(logic [9:0] e, logic [11:0] hi,
                                                   logic [15:0] lo);
        logic [27:0] raw;
        logic        sgn;
        logic [28:0] mag;
        int          top;
        int          sh;
        int          biased;
        logic [28:0] rem;
        logic [28:0] half;
        logic [28:0] sig;
        raw = {hi, lo};
        sgn = raw[27];
        if (raw == 28'd0)
            return 32'd0;
        mag = sgn ? (29'd1 << 28) - {1'b0, raw} : {1'b0, raw};
        top = 0;
        for (int i = 0; i < 29; i++)
            if (mag[i])
                top = i;
        if (top <= 23)
        begin
            sig = mag << (23 - top);
        end
        else
        begin
            sh   = top - 23;
            rem  = mag & ((29'd1 << sh) - 29'd1);
            half = 29'd1 << (sh - 1);
            sig  = mag >> sh;
            if (rem > half || (rem == half && sig[0]))
                sig = sig + 29'd1;
            if (sig == (29'd1 << 24))
            begin
                sig = sig >> 1;
                top = top + 1;
            end
        end
        biased = 127 + top - 27 + (int'(e) - 512);
        if (biased <= 0)
            return {sgn, 31'd0};
        if (biased > 254)
            biased = 254;
        return {sgn, biased[7:0], sig[22:0]};
    endfunction

    assign pending_count = expected_words.size();

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            fail_count   = 0;
            result_count = 0;
        end
        else
        begin
            if (start && !busy)
                expected_words.push_back(predict_single(exponent, fraction_high,
                                                        fraction_low));
            if (done)
            begin
                result_count = result_count + 1;
                if (expected_words.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected result %h", ieee_single);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want !== ieee_single)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h actual %h", want, ieee_single);
                    end
                end
            end
        end
    end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random requests into the converter with sender gaps
// and a drain pause, then reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import wfis_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [9:0]  exponent;
    logic [11:0] fraction_high;
    logic [15:0] fraction_low;
    logic        done;
    logic [31:0] ieee_single;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          cycle_count;
    int          sent_count;

    wide_float_to_ieee_single_unit dut (.*);

    wfis_checker checker_inst (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000)
        begin
            $display("timeout");
            $display("wide_float_to_ieee_single_unit regression: fail");
            $finish;
        end
    end

    // Hold a request until it is taken, with a random gap before it.
    task automatic send_request(logic [9:0] e, logic [27:0] f, int gap_pct);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        exponent      <= e;
        fraction_high <= f[27:16];
        fraction_low  <= f[15:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count = sent_count + 1;
    endtask

    // Drop start and wait until every expected result has come.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic send_random(int gap_pct);
        logic [27:0] f;
        logic [9:0]  e;
        int          pick;
        f    = 28'($urandom);
        pick = $urandom_range(9);
        // bias toward tie patterns, small magnitudes and near-edge exponents
        if (pick == 0)
            f = {$urandom_range(1) ? 4'hF : 4'h0, 24'h0} | (28'h1 << $urandom_range(27));
        else if (pick == 1)
            f = {f[27:4], 4'b1000};
        else if (pick == 2)
            f = $urandom_range(1) ? 28'(28'hFFFFFFF - $urandom_range(15))
                                  : 28'($urandom_range(15));
        e = 10'($urandom);
        if ($urandom_range(3) == 0)
            e = $urandom_range(1) ? 10'(10'd385 + $urandom_range(40) - 20)
                                  : 10'(10'd640 + $urandom_range(40) - 20);
        send_request(e, f, gap_pct);
    endtask

    initial
    begin
        sent_count    = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        exponent      = '0;
        fraction_high = '0;
        fraction_low  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, extremes, most negative, rounding carry, edges
        send_request(10'd512, 28'h0, 0);
        send_request(10'd1023, 28'h0, 0);
        send_request(10'd512, 28'h8000000, 0);
        send_request(10'd512, 28'h7FFFFFF, 0);
        send_request(10'd512, 28'h0000001, 0);
        send_request(10'd512, 28'hFFFFFFF, 0);
        send_request(10'd512, 28'h7FFFFF8, 0);
        send_request(10'd512, 28'h0FFFFFF, 0);
        send_request(10'd512, 28'h1000008, 0);
        send_request(10'd512, 28'h1000018, 0);
        send_request(10'd512, 28'h100000C, 0);
        send_request(10'd0, 28'h7FFFFFF, 0);
        send_request(10'd0, 28'h8000000, 0);
        send_request(10'd1023, 28'h7FFFFFF, 0);
        send_request(10'd1023, 28'h8000000, 0);
        send_request(10'd386, 28'h0000001, 0);
        send_request(10'd385, 28'h0000001, 0);
        send_request(10'd640, 28'h4000000, 0);
        send_request(10'd641, 28'h4000000, 0);
        send_request(10'h2AA, 28'hAAA5555, 0);
        send_request(10'h155, 28'h555AAAA, 0);

        for (int i = 0; i < 400; i++)
            send_random(12);
        // drain before moving on
        drain();
        for (int i = 0; i < 400; i++)
            send_random(47);
        for (int i = 0; i < 400; i++)
            send_random(0);

        drain();
        repeat (5) @(posedge clk);
        $display("sent %0d requests, %0d results checked, with and without sender gaps",
                 sent_count, result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("wide_float_to_ieee_single_unit regression: pass");
        else
            $display("wide_float_to_ieee_single_unit regression: fail");
        $finish;
    end

endmodule

[files.f]
design/wfis_pkg.sv
design/wfis_norm.sv
design/wfis_pack.sv
design/wide_float_to_ieee_single_unit.sv
sim/wfis_checker.sv
sim/testbench.sv
